@@ hw/rtl/tile_source_address_resolver_defines.svh @@
// assertion macros for the tile source address resolver
// no dependencies; included by tile_source_address_resolver.sv, which checks its own logic
`ifndef TILE_SOURCE_ADDRESS_RESOLVER_DEFINES_SVH
`define TILE_SOURCE_ADDRESS_RESOLVER_DEFINES_SVH

`ifndef SYNTHESIS

`define TSAR_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
    else $error("tsar check failed");

`define TSAR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
    else $error("tsar check failed");

`else

`define TSAR_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs)

`define TSAR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

@@ hw/rtl/tsar_pkg.sv @@
// types, constants and register indexes of the tile source address resolver
// no dependencies
`timescale 1ns / 1ps

package tsar_pkg;

  localparam int unsigned SetSlots = 3;
  localparam int unsigned NumSets  = 3;
  localparam int unsigned MapCols  = 1024;
  localparam int unsigned MapRows  = 1024;

  localparam int unsigned IdW    = 16;
  localparam int unsigned CoordW = 10;
  localparam int unsigned SizeW  = 9;
  localparam int unsigned SetW   = 2;
  localparam int unsigned SrcXW  = 16;
  localparam int unsigned SrcYW  = 24;
  localparam int unsigned DstW   = 18;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned DivCells = IdW;

  localparam logic [SizeW-1:0] TileSizeRst = 9'd16;
  localparam logic [IdW-1:0]   FirstId0Rst = 16'd1;
  localparam logic [IdW-1:0]   FirstIdNRst = 16'd65535;
  localparam logic [SizeW-1:0] ColumnsRst  = 9'd1;

  typedef enum logic [CfgIdxW-1:0] {
    RegTileSize = 3'd0,
    RegFirstId0 = 3'd1,
    RegColumns0 = 3'd2,
    RegFirstId1 = 3'd3,
    RegColumns1 = 3'd4,
    RegFirstId2 = 3'd5,
    RegColumns2 = 3'd6
  } cfg_reg_e;

  // payload handed from cell to cell along the divider chain
  typedef struct packed {
    logic [SetW-1:0]   set_index;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [SizeW-1:0]  divisor;
    logic [SizeW-1:0]  rem;
    logic [IdW-1:0]    work;
  } tsar_tok_t;

endpackage

@@ hw/rtl/tsar_select.sv @@
// front stage: tileset selection, map bounds check and local id
// depends on tsar_pkg
`timescale 1ns / 1ps

module tsar_select
  import tsar_pkg::*;
(
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [IdW-1:0]                   tile_id_i,
  input  logic [CoordW-1:0]                cell_col_i,
  input  logic [CoordW-1:0]                cell_row_i,
  input  logic [SetSlots-1:0][IdW-1:0]     first_id_i,
  input  logic [SetSlots-1:0][SizeW-1:0]   columns_i,
  output logic                             valid_o,
  output tsar_tok_t                        tok_o
);

  logic            found;
  logic [IdW-1:0]  best;
  logic [SetW-1:0] pick;
  logic [SizeW-1:0] ncols;
  logic            in_map;
  logic            hit;
  logic            valid_q;
  tsar_tok_t       tok_d;
  tsar_tok_t       tok_q;

  always_comb begin
    found = 1'b0;
    best  = '0;
    pick  = '0;
    for (int i = 0; i < NumSets; i++) begin
      if (tile_id_i >= first_id_i[i] && (!found || first_id_i[i] > best)) begin
        found = 1'b1;
        best  = first_id_i[i];
        pick  = SetW'(i);
      end
    end
    in_map = (32'(cell_col_i) < MapCols) && (32'(cell_row_i) < MapRows);
    hit    = accept_i && (tile_id_i != '0) && in_map && found;
    ncols  = columns_i[pick];
    if (ncols == '0) begin
      ncols = SizeW'(1);
    end
    tok_d.set_index = pick;
    tok_d.col       = cell_col_i;
    tok_d.row       = cell_row_i;
    tok_d.divisor   = ncols;
    tok_d.rem       = '0;
    tok_d.work      = tile_id_i - best;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hit) begin
      tok_q <= tok_d;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

endmodule

@@ hw/rtl/tsar_div_cell.sv @@
// one restoring division cell: settles one quotient bit and passes the token on
// depends on tsar_pkg
`timescale 1ns / 1ps

module tsar_div_cell
  import tsar_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  tsar_tok_t tok_i,
  output logic      valid_o,
  output tsar_tok_t tok_o
);

  logic [SizeW:0]   trial;
  logic [SizeW:0]   diff;
  logic             ge;
  logic             valid_q;
  tsar_tok_t        tok_d;
  tsar_tok_t        tok_q;

  always_comb begin
    trial = {tok_i.rem, tok_i.work[IdW-1]};
    diff  = trial - {1'b0, tok_i.divisor};
    ge    = (trial >= {1'b0, tok_i.divisor});
    tok_d = tok_i;
    tok_d.rem  = ge ? diff[SizeW-1:0] : trial[SizeW-1:0];
    tok_d.work = {tok_i.work[IdW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      tok_q <= tok_d;
    end
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

endmodule

@@ hw/rtl/tsar_scale.sv @@
// output stage: scales remainder, quotient and cell position by the tile size
// depends on tsar_pkg
`timescale 1ns / 1ps

module tsar_scale
  import tsar_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  tsar_tok_t         tok_i,
  input  logic [SizeW-1:0]  tile_size_i,
  output logic              done_o,
  output logic [SetW-1:0]   set_index_o,
  output logic [SrcXW-1:0]  src_x_o,
  output logic [SrcYW-1:0]  src_y_o,
  output logic [DstW-1:0]   dst_x_o,
  output logic [DstW-1:0]   dst_y_o
);

  logic [2*SizeW-1:0]      src_x_full;
  logic [IdW+SizeW-1:0]    src_y_full;
  logic [CoordW+SizeW-1:0] dst_x_full;
  logic [CoordW+SizeW-1:0] dst_y_full;
  logic                    done_q;
  logic [SetW-1:0]         set_index_q;
  logic [SrcXW-1:0]        src_x_q;
  logic [SrcYW-1:0]        src_y_q;
  logic [DstW-1:0]         dst_x_q;
  logic [DstW-1:0]         dst_y_q;

  assign src_x_full = tok_i.rem * tile_size_i;
  assign src_y_full = tok_i.work * (IdW+SizeW)'(tile_size_i);
  assign dst_x_full = tok_i.col * (CoordW+SizeW)'(tile_size_i);
  assign dst_y_full = tok_i.row * (CoordW+SizeW)'(tile_size_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      set_index_q <= tok_i.set_index;
      src_x_q     <= src_x_full[SrcXW-1:0];
      src_y_q     <= src_y_full[SrcYW-1:0];
      dst_x_q     <= dst_x_full[DstW-1:0];
      dst_y_q     <= dst_y_full[DstW-1:0];
    end
  end

  assign done_o      = done_q;
  assign set_index_o = set_index_q;
  assign src_x_o     = src_x_q;
  assign src_y_o     = src_y_q;
  assign dst_x_o     = dst_x_q;
  assign dst_y_o     = dst_y_q;

endmodule

@@ hw/rtl/tile_source_address_resolver.sv @@
// tile source address resolver: maps a global tile id and map cell to tileset
// and pixel positions; depends on tsar_pkg, tsar_select, tsar_div_cell, tsar_scale
// and tile_source_address_resolver_defines.svh
//
// usage
//   input: one map cell per transaction, taken at a clock edge with start_i high
//   and busy_o low; busy_o stays low, so a cell may be offered every cycle
//   output: a result is shown for exactly one cycle with done_o high; empty
//   cells, cells outside the map and ids below every first id give no result
//   pipeline: one select stage, a chain of 16 division cells and one multiply
//   stage, each registered, lie between the accepting edge and the strobe
//   throughput: one cell per cycle, set by the division chain, which settles one
//   quotient bit per cell and moves every token on each cycle
//   config: cfg_we_i writes register cfg_idx_i from cfg_wdata_i at a clock edge;
//   write only while no transaction is in flight
//   reset: registers return to their defaults and the pipeline empties at once
//   the receiver cannot stall; results are never held back
`timescale 1ns / 1ps
`include "tile_source_address_resolver_defines.svh"

module tile_source_address_resolver
  import tsar_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [IdW-1:0]      tile_id_i,
  input  logic [CoordW-1:0]   cell_col_i,
  input  logic [CoordW-1:0]   cell_row_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                done_o,
  output logic [SetW-1:0]     set_index_o,
  output logic [SrcXW-1:0]    src_x_o,
  output logic [SrcYW-1:0]    src_y_o,
  output logic [DstW-1:0]     dst_x_o,
  output logic [DstW-1:0]     dst_y_o
);

  logic                           accept;
  logic [SizeW-1:0]               tile_size_q;
  logic [SetSlots-1:0][IdW-1:0]   first_id_q;
  logic [SetSlots-1:0][SizeW-1:0] columns_q;
  logic [DivCells:0]              chain_valid;
  tsar_tok_t                      chain_tok [DivCells+1];

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_size_q   <= TileSizeRst;
      first_id_q[0] <= FirstId0Rst;
      first_id_q[1] <= FirstIdNRst;
      first_id_q[2] <= FirstIdNRst;
      columns_q[0]  <= ColumnsRst;
      columns_q[1]  <= ColumnsRst;
      columns_q[2]  <= ColumnsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegTileSize: tile_size_q   <= cfg_wdata_i[SizeW-1:0];
        RegFirstId0: first_id_q[0] <= cfg_wdata_i[IdW-1:0];
        RegColumns0: columns_q[0]  <= cfg_wdata_i[SizeW-1:0];
        RegFirstId1: first_id_q[1] <= cfg_wdata_i[IdW-1:0];
        RegColumns1: columns_q[1]  <= cfg_wdata_i[SizeW-1:0];
        RegFirstId2: first_id_q[2] <= cfg_wdata_i[IdW-1:0];
        RegColumns2: columns_q[2]  <= cfg_wdata_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  tsar_select u_select (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .tile_id_i  (tile_id_i),
    .cell_col_i (cell_col_i),
    .cell_row_i (cell_row_i),
    .first_id_i (first_id_q),
    .columns_i  (columns_q),
    .valid_o    (chain_valid[0]),
    .tok_o      (chain_tok[0])
  );

  for (genvar g = 0; g < DivCells; g++) begin : g_cell
    tsar_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[g]),
      .tok_i   (chain_tok[g]),
      .valid_o (chain_valid[g+1]),
      .tok_o   (chain_tok[g+1])
    );
  end

  tsar_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (chain_valid[DivCells]),
    .tok_i       (chain_tok[DivCells]),
    .tile_size_i (tile_size_q),
    .done_o      (done_o),
    .set_index_o (set_index_o),
    .src_x_o     (src_x_o),
    .src_y_o     (src_y_o),
    .dst_x_o     (dst_x_o),
    .dst_y_o     (dst_y_o)
  );

  // empty cells never enter the chain
  `TSAR_ASSERT_NEXT(a_empty_dropped, clk_i, rst_ni, accept && (tile_id_i == '0), !chain_valid[0])
  // the chain leaves a remainder below the column count
  `TSAR_ASSERT_IMPLIES(a_rem_below_div, clk_i, rst_ni, chain_valid[DivCells], chain_tok[DivCells].rem < chain_tok[DivCells].divisor)
  // a token leaving the chain shows as a result in the next cycle
  `TSAR_ASSERT_NEXT(a_chain_to_done, clk_i, rst_ni, chain_valid[DivCells], done_o)
  // the chosen tileset is always one that exists
  `TSAR_ASSERT_IMPLIES(a_set_in_range, clk_i, rst_ni, chain_valid[0], 32'(chain_tok[0].set_index) < NumSets)

endmodule

@@ verif/tile_source_address_resolver_test.sv @@
// self-checking testbench for tile_source_address_resolver: directed script, then random
// map cells over many register settings, each result checked by a built-in predictor or a given address
// depends on tsar_pkg and the tile_source_address_resolver rtl
`timescale 1ns / 1ps

module tile_source_address_resolver_test;
  import tsar_pkg::*;

  localparam int unsigned Latency       = 18;
  localparam int unsigned SettleCycles  = Latency + 6;
  localparam int unsigned RandomPhases  = 13;
  localparam int unsigned TilesPerPhase = 100;
  localparam int unsigned MaxPrinted    = 20;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  typedef struct packed {
    logic [SetW-1:0]  set_index;
    logic [SrcXW-1:0] src_x;
    logic [SrcYW-1:0] src_y;
    logic [DstW-1:0]  dst_x;
    logic [DstW-1:0]  dst_y;
  } tile_addr_t;

  typedef enum logic {StepTile, StepReg} step_kind_e;

  typedef struct {
    step_kind_e          kind;
    logic [IdW-1:0]      value;
    logic [CfgIdxW-1:0]  idx;
    logic [CoordW-1:0]   col;
    logic [CoordW-1:0]   row;
    bit                  known;
    bit                  hit;
    tile_addr_t          addr;
  } script_step_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  logic                busy_o;
  logic [IdW-1:0]      tile_id_i   = '0;
  logic [CoordW-1:0]   cell_col_i  = '0;
  logic [CoordW-1:0]   cell_row_i  = '0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                done_o;
  logic [SetW-1:0]     set_index_o;
  logic [SrcXW-1:0]    src_x_o;
  logic [SrcYW-1:0]    src_y_o;
  logic [DstW-1:0]     dst_x_o;
  logic [DstW-1:0]     dst_y_o;

  // predictor copy of the register file
  logic [SizeW-1:0] size_q;
  logic [IdW-1:0]   first_q [SetSlots];
  logic [SizeW-1:0] cols_q  [SetSlots];

  tile_addr_t   pending_addrs[$];
  script_step_t script[$];
  tile_addr_t   want_addr;

  int unsigned errors          = 0;
  int unsigned tiles_sent      = 0;
  int unsigned directed_tiles  = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used   = 0;

  tile_source_address_resolver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .tile_id_i   (tile_id_i),
    .cell_col_i  (cell_col_i),
    .cell_row_i  (cell_row_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .set_index_o (set_index_o),
    .src_x_o     (src_x_o),
    .src_y_o     (src_y_o),
    .dst_x_o     (dst_x_o),
    .dst_y_o     (dst_y_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending_addrs.size());
    $display("tile_source_address_resolver test failed");
    $finish;
  end

  task automatic note_error(input string msg);
    errors++;
    if (errors <= MaxPrinted) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  function automatic bit resolve_tile(input logic [IdW-1:0] id, input logic [CoordW-1:0] col,
                                      input logic [CoordW-1:0] row, output tile_addr_t addr);
    int          chosen;
    logic [IdW-1:0] best;
    int unsigned local_id;
    int unsigned ncols;
    int unsigned size;
    addr = '0;
    chosen = -1;
    best = '0;
    if (id == '0) return 1'b0;
    if (col >= MapCols || row >= MapRows) return 1'b0;
    for (int i = 0; i < NumSets && i < SetSlots; i++) begin
      if (id >= first_q[i] && (chosen < 0 || first_q[i] > best)) begin
        best = first_q[i];
        chosen = i;
      end
    end
    if (chosen < 0) return 1'b0;
    local_id = id - best;
    ncols = (cols_q[chosen] == '0) ? 1 : cols_q[chosen];
    size = size_q;
    addr.set_index = chosen[SetW-1:0];
    addr.src_x = SrcXW'((local_id % ncols) * size);
    addr.src_y = SrcYW'((local_id / ncols) * size);
    addr.dst_x = DstW'(col * size);
    addr.dst_y = DstW'(row * size);
    return 1'b1;
  endfunction

  // drives one map cell and returns at the edge that accepts it
  task automatic send_tile(input logic [IdW-1:0] id, input logic [CoordW-1:0] col,
                           input logic [CoordW-1:0] row, input int gap);
    cfg_we_i <= 1'b0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    tile_id_i  <= id;
    cell_col_i <= col;
    cell_row_i <= row;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    tiles_sent++;
  endtask

  task automatic predict_tile(input logic [IdW-1:0] id, input logic [CoordW-1:0] col,
                              input logic [CoordW-1:0] row);
    tile_addr_t addr;
    if (resolve_tile(id, col, row, addr)) pending_addrs = {pending_addrs, addr};
  endtask

  // leaves cfg_we_i high; the next transaction lowers it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      RegTileSize: size_q     = data[SizeW-1:0];
      RegFirstId0: first_q[0] = data[IdW-1:0];
      RegColumns0: cols_q[0]  = data[SizeW-1:0];
      RegFirstId1: first_q[1] = data[IdW-1:0];
      RegColumns1: cols_q[1]  = data[SizeW-1:0];
      RegFirstId2: first_q[2] = data[IdW-1:0];
      RegColumns2: cols_q[2]  = data[SizeW-1:0];
      default: ;
    endcase
  endtask

  // idle margin after the last result before registers change
  task automatic wait_drain();
    start_i <= 1'b0;
    while (pending_addrs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic add_tile(input logic [IdW-1:0] id, input logic [CoordW-1:0] col,
                          input logic [CoordW-1:0] row);
    script_step_t s;
    s = '{kind: StepTile, value: id, idx: '0, col: col, row: row, known: 1'b0, hit: 1'b0,
          addr: '0};
    script = {script, s};
  endtask

  task automatic add_known(input logic [IdW-1:0] id, input logic [CoordW-1:0] col,
                           input logic [CoordW-1:0] row, input bit hit,
                           input logic [SetW-1:0] set, input int unsigned sx,
                           input int unsigned sy, input int unsigned dx, input int unsigned dy);
    script_step_t s;
    s = '{kind: StepTile, value: id, idx: '0, col: col, row: row, known: 1'b1, hit: hit,
          addr: '{set, SrcXW'(sx), SrcYW'(sy), DstW'(dx), DstW'(dy)}};
    script = {script, s};
  endtask

  task automatic add_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    script_step_t s;
    s = '{kind: StepReg, value: data, idx: idx, col: '0, row: '0, known: 1'b0, hit: 1'b0,
          addr: '0};
    script = {script, s};
  endtask

  function automatic logic [CfgDataW-1:0] pick_span_word();
    int unsigned v;
    case ($urandom_range(0, 5))
      0: v = 0;
      1: v = 511;
      2: v = $urandom_range(1, 4);
      default: v = $urandom_range(1, 256);
    endcase
    return {7'($urandom), SizeW'(v)};
  endfunction

  function automatic logic [IdW-1:0] pick_first_id();
    case ($urandom_range(0, 3))
      0: return IdW'($urandom_range(1, 64));
      1: return IdW'($urandom_range(1, 4096));
      2: return IdW'($urandom);
      default: return first_q[$urandom_range(0, SetSlots - 1)];
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_addrs.size() == 0) begin
        note_error($sformatf("unexpected result set %0d src %0d,%0d dst %0d,%0d",
                             set_index_o, src_x_o, src_y_o, dst_x_o, dst_y_o));
      end else begin
        want_addr = pending_addrs.pop_front();
        results_checked++;
        if (set_index_o !== want_addr.set_index)
          note_error($sformatf("set_index %0d, want %0d", set_index_o, want_addr.set_index));
        if (src_x_o !== want_addr.src_x)
          note_error($sformatf("src_x %0d, want %0d", src_x_o, want_addr.src_x));
        if (src_y_o !== want_addr.src_y)
          note_error($sformatf("src_y %0d, want %0d", src_y_o, want_addr.src_y));
        if (dst_x_o !== want_addr.dst_x)
          note_error($sformatf("dst_x %0d, want %0d", dst_x_o, want_addr.dst_x));
        if (dst_y_o !== want_addr.dst_y)
          note_error($sformatf("dst_y %0d, want %0d", dst_y_o, want_addr.dst_y));
      end
    end
  end

  initial begin : stimulus
    bit             after_tiles;
    bit             burst;
    int unsigned    near_id;
    logic [IdW-1:0] id;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;

    after_tiles = 1'b0;
    size_q     = TileSizeRst;
    first_q[0] = FirstId0Rst;
    first_q[1] = FirstIdNRst;
    first_q[2] = FirstIdNRst;
    for (int i = 0; i < SetSlots; i++) cols_q[i] = ColumnsRst;

    // reset values: tile 16, set 0 from id 1, sets 1 and 2 tied at the top id
    add_known(16'd0, 10'd0, 10'd0, 1'b0, 2'd0, 0, 0, 0, 0);
    add_known(16'd1, 10'd0, 10'd0, 1'b1, 2'd0, 0, 0, 0, 0);
    add_known(16'd2, 10'd5, 10'd7, 1'b1, 2'd0, 0, 16, 80, 112);
    add_known(16'hFFFF, 10'd1023, 10'd1023, 1'b1, 2'd1, 0, 0, 16368, 16368);
    add_tile(16'h5555, 10'h2AA, 10'h155);
    // zero column count on set 1, tie between sets 1 and 2
    add_cfg(RegTileSize, 16'd256);
    add_cfg(RegFirstId0, 16'd100);
    add_cfg(RegColumns0, 16'd256);
    add_cfg(RegFirstId1, 16'd200);
    add_cfg(RegColumns1, 16'd0);
    add_cfg(RegFirstId2, 16'd200);
    add_cfg(RegColumns2, 16'd7);
    add_known(16'd99, 10'd1, 10'd1, 1'b0, 2'd0, 0, 0, 0, 0);
    add_known(16'd100, 10'd1023, 10'd0, 1'b1, 2'd0, 0, 0, 261888, 0);
    add_tile(16'd355, 10'd4, 10'd9);
    add_tile(16'd199, 10'd0, 10'd1023);
    add_tile(16'hFFFF, 10'd512, 10'd511);
    add_tile(16'hAAAA, 10'h155, 10'h2AA);
    // all-ones writes to the tile size, first id 0 and column count 2: products wrap at the field widths
    add_cfg(RegTileSize, 16'hFFFF);
    add_cfg(RegFirstId0, 16'hFFFF);
    add_cfg(RegFirstId1, 16'd1);
    add_cfg(RegColumns1, 16'd3);
    add_cfg(RegFirstId2, 16'd1);
    add_cfg(RegColumns2, 16'hFFFF);
    add_tile(16'hFFFF, 10'd1023, 10'd1023);
    add_tile(16'd1, 10'd1, 10'd2);
    add_tile(16'd65534, 10'd300, 10'd700);
    add_cfg(RegTileSize, 16'd0);
    add_cfg(RegUnused, 16'h1234);
    add_known(16'd500, 10'd3, 10'd4, 1'b1, 2'd1, 0, 0, 0, 0);
    // set 2 sits between sets 0 and 1
    add_cfg(RegTileSize, 16'd1);
    add_cfg(RegFirstId0, 16'd5);
    add_cfg(RegFirstId1, 16'd20);
    add_cfg(RegFirstId2, 16'd10);
    add_cfg(RegColumns2, 16'd1);
    add_tile(16'd15, 10'd8, 10'd9);
    add_tile(16'd25, 10'd10, 10'd11);
    add_tile(16'd7, 10'd12, 10'd13);
    add_known(16'd4, 10'd6, 10'd6, 1'b0, 2'd0, 0, 0, 0, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].kind == StepReg) begin
        if (after_tiles) begin
          wait_drain();
          settings_used++;
          after_tiles = 1'b0;
        end
        write_reg(script[i].idx, script[i].value);
      end else begin
        send_tile(script[i].value, script[i].col, script[i].row, $urandom_range(0, 4));
        directed_tiles++;
        after_tiles = 1'b1;
        if (script[i].known) begin
          if (script[i].hit) pending_addrs = {pending_addrs, script[i].addr};
        end else begin
          predict_tile(script[i].value, script[i].col, script[i].row);
        end
      end
    end

    for (int p = 0; p < RandomPhases; p++) begin
      wait_drain();
      settings_used++;
      // even indexes hold the 9-bit fields, odd ones the first ids
      for (int r = RegTileSize; r <= RegColumns2; r++) begin
        case (p)
          0: write_reg(r[CfgIdxW-1:0], 16'd1);
          1: write_reg(r[CfgIdxW-1:0], 16'hFFFF);
          default: write_reg(r[CfgIdxW-1:0], (r % 2 == 0) ? pick_span_word() : pick_first_id());
        endcase
      end
      if ($urandom_range(0, 3) == 0) write_reg(RegUnused, CfgDataW'($urandom));
      burst = (p % 3 == 2);
      repeat (TilesPerPhase) begin
        case ($urandom_range(0, 9))
          0: id = '0;
          1: id = IdW'($urandom);
          2: id = '1;
          default: begin
            near_id = first_q[$urandom_range(0, SetSlots - 1)] + $urandom_range(0, 700);
            id = (near_id > 65535) ? '1 : IdW'(near_id);
          end
        endcase
        col = CoordW'($urandom);
        row = CoordW'($urandom);
        case ($urandom_range(0, 7))
          0: col = '0;
          1: col = '1;
          2: row = '0;
          3: row = '1;
          default: ;
        endcase
        send_tile(id, col, row, burst ? 0 : $urandom_range(0, 4));
        predict_tile(id, col, row);
      end
    end

    wait_drain();
    $display("sent %0d map cells (%0d directed) under %0d register settings",
             tiles_sent, directed_tiles, settings_used);
    $display("checked %0d tile addresses, %0d mismatches", results_checked, errors);
    if (errors == 0) begin
      $display("tile_source_address_resolver test passed");
    end else begin
      $display("tile_source_address_resolver test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/tsar_pkg.sv
hw/rtl/tsar_select.sv
hw/rtl/tsar_div_cell.sv
hw/rtl/tsar_scale.sv
hw/rtl/tile_source_address_resolver.sv
verif/tile_source_address_resolver_test.sv
